// ----- hw/rtl/sls_pkg.sv -----
package sls_pkg;

  localparam int MAX_TAPS = 6;
  localparam int DEPTH    = 2 * MAX_TAPS - 1;
  localparam int SAMPLE_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int TAP_W    = 3;
  localparam int SEEN_W   = 3;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int ADDR_W   = 5;
  localparam int PROD_W   = SAMPLE_W + WEIGHT_W;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 3'd7;
  localparam logic [TAP_W-1:0] TAP_RESET = 3'd3;
  localparam logic [MAX_TAPS-1:0][WEIGHT_W-1:0] WEIGHT_RESET =
    {16'd0, 16'd0, 16'd0, 16'd6, 16'd25, 16'd41};

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    REG_TAP_COUNT = 3'd0,
    REG_WEIGHT_0  = 3'd1,
    REG_WEIGHT_1  = 3'd2,
    REG_WEIGHT_2  = 3'd3,
    REG_WEIGHT_3  = 3'd4,
    REG_WEIGHT_4  = 3'd5,
    REG_WEIGHT_5  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [TAP_W-1:0]                   tap_count;
    logic [MAX_TAPS-1:0][WEIGHT_W-1:0]  weights;
  } cfg_t;

  // one result on its way down the cell chain
  typedef struct packed {
    logic                               valid;
    logic                               last_res;
    sample_t                            acc;
    logic [MAX_TAPS-1:0][SAMPLE_W-1:0]  pairs;
  } job_t;

endpackage

// ----- hw/rtl/sls_regs.sv -----
module sls_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sls_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output sls_pkg::cfg_t             cfg
);
  import sls_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_count <= TAP_RESET;
      cfg.weights   <= WEIGHT_RESET;
    end else if (wr) begin
      case (idx)
        REG_TAP_COUNT: cfg.tap_count  <= pwdata[TAP_W-1:0];
        REG_WEIGHT_0:  cfg.weights[0] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_1:  cfg.weights[1] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_2:  cfg.weights[2] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_3:  cfg.weights[3] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_4:  cfg.weights[4] <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_5:  cfg.weights[5] <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TAP_COUNT: prdata = {{(32-TAP_W){1'b0}}, cfg.tap_count};
      REG_WEIGHT_0:  prdata = {{(32-WEIGHT_W){1'b0}}, cfg.weights[0]};
      REG_WEIGHT_1:  prdata = {{(32-WEIGHT_W){1'b0}}, cfg.weights[1]};
      REG_WEIGHT_2:  prdata = {{(32-WEIGHT_W){1'b0}}, cfg.weights[2]};
      REG_WEIGHT_3:  prdata = {{(32-WEIGHT_W){1'b0}}, cfg.weights[3]};
      REG_WEIGHT_4:  prdata = {{(32-WEIGHT_W){1'b0}}, cfg.weights[4]};
      REG_WEIGHT_5:  prdata = {{(32-WEIGHT_W){1'b0}}, cfg.weights[5]};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/sls_front.sv -----
module sls_front (
  input  logic                       clk,
  input  logic                       rst,
  input  sls_pkg::cfg_t              cfg,
  input  logic                       adv,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sls_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                       in_last,
  output sls_pkg::job_t              job
);
  import sls_pkg::*;

  sample_t             window      [DEPTH];
  sample_t             window_next [DEPTH];
  logic [SEEN_W-1:0]   seen, seen_next;
  logic                flush, flush_next;
  logic [TAP_W-1:0]    fj, fj_next;
  logic [TAP_W-1:0]    taps, reach, m, j;
  logic                accept, issue, last_res;
  logic [IDX_W-1:0]    lo, hi;

  // effective radius: zero acts as one, clamp at the weight count
  always_comb begin
    if (cfg.tap_count == '0) begin
      taps = TAP_W'(1);
    end else if (cfg.tap_count > TAP_W'(MAX_TAPS)) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = cfg.tap_count;
    end
  end

  assign reach    = taps - TAP_W'(1);
  assign m        = (seen < reach) ? seen : reach;
  assign in_ready = adv & ~flush;
  assign accept   = in_valid & in_ready;

  // first sample of a line fills the window with the left border
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      window_next[i] = window[i];
    end
    if (accept) begin
      if (seen == '0) begin
        for (int i = 0; i < DEPTH; i++) begin
          window_next[i] = in_sample;
        end
      end else begin
        for (int i = DEPTH - 1; i > 0; i--) begin
          window_next[i] = window[i-1];
        end
        window_next[0] = in_sample;
      end
    end
  end

  always_comb begin
    issue      = 1'b0;
    j          = '0;
    last_res   = 1'b0;
    seen_next  = seen;
    flush_next = flush;
    fj_next    = fj;
    if (flush) begin
      issue    = adv;
      j        = fj;
      last_res = (fj == '0);
      if (adv) begin
        if (fj == '0) begin
          flush_next = 1'b0;
        end else begin
          fj_next = fj - TAP_W'(1);
        end
      end
    end else if (accept) begin
      if (in_last) begin
        issue     = 1'b1;
        j         = m;
        last_res  = (m == '0);
        seen_next = '0;
        if (m != '0) begin
          flush_next = 1'b1;
          fj_next    = m - TAP_W'(1);
        end
      end else begin
        issue     = (seen >= reach);
        j         = reach;
        seen_next = (seen < SEEN_MAX) ? seen + SEEN_W'(1) : SEEN_MAX;
      end
    end
  end

  // pair for distance d: clamped newer side plus older side
  always_comb begin
    job.valid    = issue;
    job.last_res = last_res;
    job.acc      = '0;
    job.pairs[0] = window_next[IDX_W'(j)];
    lo           = '0;
    hi           = '0;
    for (int d = 1; d < MAX_TAPS; d++) begin
      lo = (IDX_W'(j) >= IDX_W'(d)) ? IDX_W'(j) - IDX_W'(d) : '0;
      hi = IDX_W'(j) + IDX_W'(d);
      if (TAP_W'(d) < taps) begin
        job.pairs[d] = window_next[lo] + window_next[hi];
      end else begin
        job.pairs[d] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      window[i] <= window_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      flush <= 1'b0;
      fj    <= '0;
    end else begin
      seen  <= seen_next;
      flush <= flush_next;
      fj    <= fj_next;
    end
  end

endmodule

// ----- hw/rtl/sls_cell.sv -----
module sls_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [sls_pkg::WEIGHT_W-1:0] weight,
  input  sls_pkg::job_t               job_in,
  output sls_pkg::job_t               job_out
);
  import sls_pkg::*;

  logic [PROD_W-1:0] prod;

  // each cell takes the lowest pair and hands the rest on
  assign prod = PROD_W'(job_in.pairs[0]) * PROD_W'(weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_out.valid <= 1'b0;
    end else if (adv) begin
      job_out.valid <= job_in.valid;
    end
    if (adv) begin
      job_out.last_res <= job_in.last_res;
      job_out.acc      <= job_in.acc + prod[SAMPLE_W-1:0];
      job_out.pairs    <= job_in.pairs >> SAMPLE_W;
    end
  end

endmodule

// ----- hw/rtl/sls_out.sv -----
module sls_out (
  input  logic                       clk,
  input  logic                       rst,
  output logic                       adv,
  input  sls_pkg::job_t              job_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sls_pkg::SAMPLE_W-1:0] out_data,
  output logic                       out_last
);
  import sls_pkg::*;

  logic    skid_valid;
  sample_t skid_data;
  logic    skid_last;
  logic    push, pop;

  // chain moves whenever the skid slot is free
  assign adv  = ~skid_valid;
  assign push = adv & job_in.valid;
  assign pop  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
        out_last <= skid_last;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= job_in.acc;
        skid_last <= job_in.last_res;
      end else begin
        out_data <= job_in.acc;
        out_last <= job_in.last_res;
      end
    end
  end

endmodule

// ----- hw/rtl/symmetric_line_smoother.sv -----
// symmetric line smoother: symmetric fir smoothing of one image line
// s_axis carries one sample a transfer, tlast on the final sample of a line;
// m_axis carries one smoothed value a transfer, tlast on the last one of a line.
// the apb port holds the radius (tap_count) at 0 and weight_i at 4*(i+1);
// write them only while no line is in flight.
// a sample is taken every cycle while s_axis_tready is high; a sample that
// completes position c gives its result on m_axis through six multiply-add
// cells, one per kernel weight, then the output register.
// a tlast sample releases up to min(seen, radius-1)+1 results, one a cycle
// while the chain advances; s_axis_tready stays low until the extra results, at most five per line, are issued.
// borders replicate the first and last sample of the line.
// reset restores the register defaults (radius 3, weights 41 25 6) and
// starts a fresh line; no clearing pass is needed.
// when m_axis stalls the cell chain holds once the skid slot fills, and
// s_axis_tready drops in the same cycle; nothing is lost.
module symmetric_line_smoother (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sls_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // [31:0] sample
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // [31:0] smoothed
  output logic                        m_axis_tlast
);
  import sls_pkg::*;

  cfg_t cfg;
  logic adv;
  job_t chain [MAX_TAPS+1];

  sls_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .adv       (adv),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .job       (chain[0])
  );

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    sls_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .weight  (cfg.weights[k]),
      .job_in  (chain[k]),
      .job_out (chain[k+1])
    );
  end

  sls_out u_out (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .job_in    (chain[MAX_TAPS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- tb/sls_checker.sv -----
module sls_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sls_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // [31:0] sample
  input  logic                        s_axis_tlast,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [31:0]                 m_axis_tdata,   // [31:0] smoothed
  input  logic                        m_axis_tlast,
  output int                          errors,
  output int                          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import sls_pkg::*;

  typedef struct packed {
    sample_t smoothed;
    logic    final_res;
  } smoothed_res_t;

  logic [TAP_W-1:0]    radius_reg;
  logic [WEIGHT_W-1:0] weight [MAX_TAPS];
  sample_t             line_window [DEPTH];
  int                  seen_count;
  int                  fail_count;
  smoothed_res_t       expected_smoothed [$];

  function automatic int clamp_age(input int age);
    if (age < 0) return 0;
    if (age > DEPTH - 1) return DEPTH - 1;
    return age;
  endfunction

  function automatic int taps_in_use();
    if (radius_reg == 0) return 1;
    if (radius_reg > MAX_TAPS) return MAX_TAPS;
    return int'(radius_reg);
  endfunction

  // sum centred on the sample of the given age, wrapping at 32 bits
  function automatic sample_t weighted_sum(input int centre, input int taps);
    sample_t acc;
    sample_t pair;
    acc = line_window[clamp_age(centre)] * weight[0];
    for (int d = 1; d < taps; d++) begin
      pair = line_window[clamp_age(centre - d)] + line_window[clamp_age(centre + d)];
      acc  = acc + pair * weight[d];
    end
    return acc;
  endfunction

  function automatic void smooth_sample(input sample_t x, input logic line_end);
    int taps;
    int n;
    int first_pos;
    taps = taps_in_use();
    n    = seen_count;
    if (n == 0) begin
      // fresh line: older entries hold the left border
      for (int i = 0; i < DEPTH; i++) line_window[i] = x;
    end else begin
      for (int i = DEPTH - 1; i > 0; i--) line_window[i] = line_window[i-1];
      line_window[0] = x;
    end
    if (line_end) begin
      first_pos = (n < taps - 1) ? n : taps - 1;
      for (int j = first_pos; j >= 0; j--)
        expected_smoothed.push_back('{weighted_sum(j, taps), j == 0});
      seen_count = 0;
    end else begin
      if (n >= taps - 1)
        expected_smoothed.push_back('{weighted_sum(taps - 1, taps), 1'b0});
      seen_count = (n < int'(SEEN_MAX)) ? n + 1 : int'(SEEN_MAX);
    end
  endfunction

  always @(posedge clk) begin
    smoothed_res_t exp_res;
    logic [2:0]    idx;
    if (rst) begin
      radius_reg = TAP_RESET;
      for (int i = 0; i < MAX_TAPS; i++) weight[i] = WEIGHT_RESET[i];
      for (int i = 0; i < DEPTH; i++) line_window[i] = '0;
      seen_count = 0;
      fail_count = 0;
      expected_smoothed.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[4:2];
        if (idx == REG_TAP_COUNT) radius_reg = pwdata[TAP_W-1:0];
        else if (idx <= REG_WEIGHT_5) weight[idx - REG_WEIGHT_0] = pwdata[WEIGHT_W-1:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_smoothed.size() == 0) begin
          $error("unexpected m_axis transfer: smoothed %0d tlast %0b",
                 $signed(m_axis_tdata), m_axis_tlast);
          fail_count++;
        end else begin
          exp_res = expected_smoothed.pop_front();
          if (m_axis_tdata !== exp_res.smoothed) begin
            $error("smoothed: expected %0d, actual %0d",
                   $signed(exp_res.smoothed), $signed(m_axis_tdata));
            fail_count++;
          end
          if (m_axis_tlast !== exp_res.final_res) begin
            $error("final_res: expected %0b, actual %0b", exp_res.final_res, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) smooth_sample(s_axis_tdata, s_axis_tlast);
    end
    pending <= expected_smoothed.size();
    errors  <= fail_count;
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import sls_pkg::*;

  localparam logic [2:0] IDX_UNMAPPED = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 220;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // [31:0] sample
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [31:0] smoothed
  logic              m_axis_tlast;

  int errors;
  int pending;
  int samples_sent = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  symmetric_line_smoother DUT (.*);

  sls_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) m_axis_tready <= steady || ($urandom_range(0, 99) >= 15);

  // stall watchdog: any transfer on any port restarts the count
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("symmetric_line_smoother test failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [31:0] value, input logic line_end);
    while (!steady && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= line_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    samples_sent++;
  endtask

  // stop the stream and let every outstanding result drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // the bus returns to idle after the access phase before the next setup
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_line(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  task automatic load_random_config(input bit extreme);
    write_reg(REG_TAP_COUNT, $urandom_range(0, 7));
    for (int i = 0; i < MAX_TAPS; i++)
      write_reg(3'(REG_WEIGHT_0 + i),
                extreme ? ($urandom_range(0, 1) ? 32'hFFFF : 32'h0) : $urandom);
  endtask

  initial begin
    int phase;
    int phase_start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: single-sample line, then a short line of extremes
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);

    // radius zero behaves as one, all weights at full scale
    settle();
    write_reg(REG_TAP_COUNT, 32'd0);
    for (int i = 0; i < MAX_TAPS; i++) write_reg(3'(REG_WEIGHT_0 + i), 32'hFFFF_FFFF);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);

    // radius above the weight count, plus a write past the register map
    settle();
    write_reg(REG_TAP_COUNT, 32'd7);
    write_reg(REG_WEIGHT_0, 32'd1);
    write_reg(REG_WEIGHT_1, 32'hFFFF);
    write_reg(REG_WEIGHT_2, 32'd0);
    write_reg(REG_WEIGHT_3, 32'h8000);
    write_reg(REG_WEIGHT_4, 32'd1);
    write_reg(REG_WEIGHT_5, 32'hFFFF);
    write_reg(IDX_UNMAPPED, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_sample(32'h1000_0000 * i + 32'h0123_4567, i == 7);

    // radius changed part-way through a line
    settle();
    write_reg(REG_TAP_COUNT, 32'd2);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'hFFFF_FFF0, 1'b0);
    settle();
    write_reg(REG_TAP_COUNT, 32'd5);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h1234_5678, 1'b1);

    phase_start = samples_sent;
    phase = 0;
    while (samples_sent - phase_start < RANDOM_ITEMS) begin
      settle();
      load_random_config(phase % 3 == 0);
      steady = (phase == 2);
      for (int k = 0; k < 30; ) begin
        int len;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_line(len);
        k += len;
      end
      phase++;
    end
    steady = 1'b0;

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("symmetric_line_smoother test passed");
    else
      $display("symmetric_line_smoother test failed");
    $finish;
  end

endmodule
